FILE: rtl/core/cba_pkg.sv
// ============================================================================
// cba_pkg
// Shared types and constants of the contiguous block allocator: sizes of the
// block map, command and result codes, and the controller/datapath structs.
// ============================================================================
package cba_pkg;

	// Store geometry. BLOCK_BYTES must be a power of two.
	localparam int NUM_BLOCKS  = 1024;
	localparam int BLOCK_BYTES = 4096;
	localparam int BLK_SHIFT   = $clog2(BLOCK_BYTES);

	// Field widths of the request and response transactions.
	localparam int CMD_W   = 2;
	localparam int BYTES_W = 23;
	localparam int IDX_W   = 10;

	// The map is kept as rows of WORD_W used bits.
	localparam int WORD_W = 16;
	localparam int BIT_W  = $clog2(WORD_W);
	localparam int ROWS   = NUM_BLOCKS / WORD_W;
	localparam int ROW_W  = $clog2(ROWS);

	// Run lengths and block counts up to NUM_BLOCKS plus one row.
	localparam int CNT_W  = IDX_W + 1;
	localparam int SUM_W  = BYTES_W + 1;
	localparam int NEED_W = SUM_W - BLK_SHIFT;

	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC_RUN = 2'd0,
		CMD_ALLOC_ONE = 2'd1,
		CMD_FREE      = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MARK,
		ST_RESULT
	} state_t;

	typedef enum logic [1:0] {
		RES_NONE,
		RES_FAIL,
		RES_ALLOC
	} res_t;

	typedef struct packed {
		logic load;
		logic scan;
		logic mark;
		logic out_load;
		res_t res;
	} ctrl_cmd_t;

	typedef struct packed {
		logic need_zero;
		logic need_big;
		logic free_empty;
		logic scan_hit;
		logic scan_miss;
		logic mark_done;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: rtl/core/cba_ifs.sv
// ============================================================================
// cba_ifs
// Valid/ready channels of the allocator: the request channel and the
// response channel, each with a source and a sink modport.
// ============================================================================
interface cba_req_if;
	logic                        valid;
	logic                        ready;
	logic [cba_pkg::CMD_W-1:0]   cmd;
	logic [cba_pkg::BYTES_W-1:0] byte_count;
	logic [cba_pkg::IDX_W-1:0]   free_first;
	logic [cba_pkg::IDX_W-1:0]   free_last;

	modport source (output valid, cmd, byte_count, free_first, free_last, input ready);
	modport sink (input valid, cmd, byte_count, free_first, free_last, output ready);
endinterface

interface cba_rsp_if;
	logic                      valid;
	logic                      ready;
	logic                      status;
	logic                      has_blocks;
	logic [cba_pkg::IDX_W-1:0] first_block;
	logic [cba_pkg::IDX_W-1:0] last_block;

	modport source (output valid, status, has_blocks, first_block, last_block, input ready);
	modport sink (input valid, status, has_blocks, first_block, last_block, output ready);
endinterface

FILE: rtl/core/cba_ram.sv
// ============================================================================
// cba_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ============================================================================
module cba_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/core/cba_ctrl.sv
// ============================================================================
// cba_ctrl
// Sequencer of the allocator: takes a request, steers the datapath through
// the map scan and the row update, and hands the result to the output stage.
// ============================================================================
module cba_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      req_valid,
	input  logic [cba_pkg::CMD_W-1:0] req_cmd,
	output logic                      req_ready,
	input  cba_pkg::dp_stat_t         stat,
	output cba_pkg::ctrl_cmd_t        cmd
);

	cba_pkg::state_t state_q, state_d;
	cba_pkg::res_t   res_q, res_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cba_pkg::ST_IDLE;
			res_q   <= cba_pkg::RES_NONE;
		end else begin
			state_q <= state_d;
			res_q   <= res_d;
		end
	end

	// Next state and the result kind that goes with it.
	always_comb begin
		state_d = state_q;
		res_d   = res_q;
		unique case (state_q)
			cba_pkg::ST_IDLE: begin
				if (req_valid) begin
					res_d   = cba_pkg::RES_NONE;
					state_d = cba_pkg::ST_RESULT;
					unique case (req_cmd)
						cba_pkg::CMD_ALLOC_RUN: begin
							if (stat.need_big) begin
								res_d = cba_pkg::RES_FAIL;
							end else if (!stat.need_zero) begin
								state_d = cba_pkg::ST_SCAN;
							end
						end
						cba_pkg::CMD_ALLOC_ONE: begin
							state_d = cba_pkg::ST_SCAN;
						end
						cba_pkg::CMD_FREE: begin
							if (!stat.free_empty) begin
								state_d = cba_pkg::ST_MARK;
							end
						end
						default: begin
							state_d = cba_pkg::ST_RESULT;
						end
					endcase
				end
			end
			cba_pkg::ST_SCAN: begin
				if (stat.scan_hit) begin
					res_d   = cba_pkg::RES_ALLOC;
					state_d = cba_pkg::ST_MARK;
				end else if (stat.scan_miss) begin
					res_d   = cba_pkg::RES_FAIL;
					state_d = cba_pkg::ST_RESULT;
				end
			end
			cba_pkg::ST_MARK: begin
				if (stat.mark_done) begin
					state_d = cba_pkg::ST_RESULT;
				end
			end
			cba_pkg::ST_RESULT: begin
				if (stat.out_free) begin
					state_d = cba_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = cba_pkg::ST_IDLE;
			end
		endcase
	end

	// Datapath commands.
	always_comb begin
		req_ready    = (state_q == cba_pkg::ST_IDLE);
		cmd.load     = (state_q == cba_pkg::ST_IDLE) && req_valid;
		cmd.scan     = (state_q == cba_pkg::ST_SCAN);
		cmd.mark     = (state_q == cba_pkg::ST_MARK);
		cmd.out_load = (state_q == cba_pkg::ST_RESULT) && stat.out_free;
		cmd.res      = res_q;
	end

endmodule

FILE: rtl/core/cba_datapath.sv
// ============================================================================
// cba_datapath
// Block map storage and the row-wide scan and update logic, plus the
// response register.
// ============================================================================
module cba_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  cba_pkg::ctrl_cmd_t          cmd,
	output cba_pkg::dp_stat_t           stat,
	input  logic [cba_pkg::CMD_W-1:0]   req_cmd,
	input  logic [cba_pkg::BYTES_W-1:0] req_byte_count,
	input  logic [cba_pkg::IDX_W-1:0]   req_free_first,
	input  logic [cba_pkg::IDX_W-1:0]   req_free_last,
	input  logic                        rsp_ready,
	output logic                        rsp_valid,
	output logic                        rsp_status,
	output logic                        rsp_has_blocks,
	output logic [cba_pkg::IDX_W-1:0]   rsp_first_block,
	output logic [cba_pkg::IDX_W-1:0]   rsp_last_block
);

	localparam int WORD_W = cba_pkg::WORD_W;
	localparam int BIT_W  = cba_pkg::BIT_W;
	localparam int ROW_W  = cba_pkg::ROW_W;
	localparam int IDX_W  = cba_pkg::IDX_W;
	localparam int CNT_W  = cba_pkg::CNT_W;
	localparam int SUM_W  = cba_pkg::SUM_W;
	localparam int NEED_W = cba_pkg::NEED_W;

	// Request decode.
	logic [SUM_W-1:0]  need_sum;
	logic [NEED_W-1:0] need_full;
	logic [IDX_W-1:0]  free_hi;
	logic              is_free;

	assign need_sum  = SUM_W'(req_byte_count) + SUM_W'(cba_pkg::BLOCK_BYTES - 1);
	assign need_full = need_sum[SUM_W-1:cba_pkg::BLK_SHIFT];
	assign is_free   = (req_cmd == cba_pkg::CMD_FREE);
	assign free_hi   = (CNT_W'(req_free_last) > CNT_W'(cba_pkg::NUM_BLOCKS - 1)) ?
		IDX_W'(cba_pkg::NUM_BLOCKS - 1) : req_free_last;

	// Operation registers.
	logic [CNT_W-1:0]  need_q;
	logic [CNT_W-1:0]  carry_q;
	logic [IDX_W-1:0]  lo_q, hi_q;
	logic              set_q;
	logic [ROW_W-1:0]  rd_row_q;
	logic [ROW_W-1:0]  proc_row_s1;
	logic              proc_vld_s1;
	logic              rv_s1;
	logic [cba_pkg::ROWS-1:0] row_vld_q;

	// Map row read back in the cycle after its address.
	logic [WORD_W-1:0] rd_word, old_word, word_free, wr_word, mask;
	logic              wr_en;

	assign old_word  = rv_s1 ? rd_word : '0;
	assign word_free = ~old_word;

	// Free run length ending at each bit of the current row.
	logic [CNT_W-1:0]  run_len [WORD_W];
	logic [WORD_W-1:0] hit_vec;
	logic [BIT_W-1:0]  hit_pos;
	logic [IDX_W-1:0]  end_idx, start_idx;

	always_comb begin
		logic             seen;
		logic [BIT_W-1:0] pos;
		seen = 1'b0;
		pos  = '0;
		for (int i = 0; i < WORD_W; i++) begin
			seen = 1'b0;
			pos  = '0;
			for (int j = 0; j < WORD_W; j++) begin
				if (j < i && !word_free[j]) begin
					seen = 1'b1;
					pos  = BIT_W'(j);
				end
			end
			if (!word_free[i]) begin
				run_len[i] = '0;
			end else if (seen) begin
				run_len[i] = CNT_W'(BIT_W'(i) - pos);
			end else begin
				run_len[i] = carry_q + CNT_W'(i + 1);
			end
			hit_vec[i] = (run_len[i] >= need_q);
		end
	end

	always_comb begin
		hit_pos = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (hit_vec[i]) begin
				hit_pos = BIT_W'(i);
			end
		end
	end

	assign end_idx   = {proc_row_s1, hit_pos};
	assign start_idx = IDX_W'(end_idx + IDX_W'(1) - need_q[IDX_W-1:0]);

	// Row update: set or clear the bits of the row that fall in [lo, hi].
	always_comb begin
		for (int b = 0; b < WORD_W; b++) begin
			mask[b] = ((proc_row_s1 != lo_q[IDX_W-1:BIT_W]) || (BIT_W'(b) >= lo_q[BIT_W-1:0]))
				&& ((proc_row_s1 != hi_q[IDX_W-1:BIT_W]) || (BIT_W'(b) <= hi_q[BIT_W-1:0]));
		end
		wr_word = set_q ? (old_word | mask) : (old_word & ~mask);
	end

	assign wr_en = cmd.mark && proc_vld_s1;

	logic scan_hit, issue, out_valid_q;

	assign scan_hit = cmd.scan && proc_vld_s1 && (|hit_vec);
	assign issue    = (cmd.scan && !scan_hit) || cmd.mark;

	always_comb begin
		stat.need_zero  = (req_byte_count == '0);
		stat.need_big   = (need_full > NEED_W'(cba_pkg::NUM_BLOCKS));
		stat.free_empty = (req_free_first > free_hi);
		stat.scan_hit   = scan_hit;
		stat.scan_miss  = cmd.scan && proc_vld_s1 && !(|hit_vec)
			&& (proc_row_s1 == ROW_W'(cba_pkg::ROWS - 1));
		stat.mark_done  = wr_en && (proc_row_s1 == hi_q[IDX_W-1:BIT_W]);
		stat.out_free   = !out_valid_q || rsp_ready;
	end

	cba_ram #(
		.WIDTH(WORD_W),
		.DEPTH(cba_pkg::ROWS)
	) u_map (
		.clk   (clk),
		.we    (wr_en),
		.waddr (proc_row_s1),
		.wdata (wr_word),
		.raddr (rd_row_q),
		.rdata (rd_word)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			proc_vld_s1 <= 1'b0;
			row_vld_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load || scan_hit) begin
				proc_vld_s1 <= 1'b0;
			end else if (issue) begin
				proc_vld_s1 <= 1'b1;
			end
			if (wr_en) begin
				row_vld_q[proc_row_s1] <= 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload and pointers.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			need_q   <= (req_cmd == cba_pkg::CMD_ALLOC_ONE) ? CNT_W'(1) : need_full[CNT_W-1:0];
			carry_q  <= '0;
			lo_q     <= req_free_first;
			hi_q     <= free_hi;
			set_q    <= !is_free;
			rd_row_q <= is_free ? req_free_first[IDX_W-1:BIT_W] : '0;
		end else if (scan_hit) begin
			lo_q     <= start_idx;
			hi_q     <= end_idx;
			rd_row_q <= start_idx[IDX_W-1:BIT_W];
		end else if (issue) begin
			rd_row_q    <= rd_row_q + ROW_W'(1);
			proc_row_s1 <= rd_row_q;
			rv_s1       <= row_vld_q[rd_row_q];
			if (cmd.scan && proc_vld_s1) begin
				carry_q <= run_len[WORD_W-1];
			end
		end

		if (cmd.out_load) begin
			unique case (cmd.res)
				cba_pkg::RES_ALLOC: begin
					rsp_status      <= 1'b0;
					rsp_has_blocks  <= 1'b1;
					rsp_first_block <= lo_q;
					rsp_last_block  <= hi_q;
				end
				cba_pkg::RES_FAIL: begin
					rsp_status      <= 1'b1;
					rsp_has_blocks  <= 1'b0;
					rsp_first_block <= '0;
					rsp_last_block  <= '0;
				end
				default: begin
					rsp_status      <= 1'b0;
					rsp_has_blocks  <= 1'b0;
					rsp_first_block <= '0;
					rsp_last_block  <= '0;
				end
			endcase
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

FILE: rtl/core/contiguous_block_allocator.sv
// ============================================================================
// contiguous_block_allocator
// First-fit allocator of contiguous runs over a bitmap of 1024 used blocks.
// ============================================================================
// Usage. A request transaction on req carries a command: allocate a run
// large enough for byte_count bytes, allocate one block, or free the
// inclusive range free_first..free_last. Every request yields exactly one
// response transaction on rsp with status, has_blocks and the first and
// last block of the allocated run.
// The map is kept in a 64 x 16 RAM. A scan reads one row per cycle and
// finds the lowest fitting run in that row. An allocation scans rows
// until a run fits and then marks the rows of that run; a free marks the
// rows it covers, and commands that touch no map rows go straight to the
// result without a pass over the map.
// The next request is taken once the previous one has reached the response
// register; a stalled receiver holds that register and blocks the
// controller only when a further result is ready to go out.
// Reset clears the per-row valid flags at once, so the whole map reads as
// free right after reset with no clearing pass.
// ============================================================================
module contiguous_block_allocator (
	input  logic      clk,
	input  logic      arst_n,
	cba_req_if.sink   req,
	cba_rsp_if.source rsp
);

	cba_pkg::ctrl_cmd_t ctrl_cmd;
	cba_pkg::dp_stat_t  dp_stat;
	logic               req_ready;

	// The controller owns the sequence; the datapath owns the map.
	cba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.cmd),
		.req_ready (req_ready),
		.stat      (dp_stat),
		.cmd       (ctrl_cmd)
	);

	cba_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (ctrl_cmd),
		.stat            (dp_stat),
		.req_cmd         (req.cmd),
		.req_byte_count  (req.byte_count),
		.req_free_first  (req.free_first),
		.req_free_last   (req.free_last),
		.rsp_ready       (rsp.ready),
		.rsp_valid       (rsp.valid),
		.rsp_status      (rsp.status),
		.rsp_has_blocks  (rsp.has_blocks),
		.rsp_first_block (rsp.first_block),
		.rsp_last_block  (rsp.last_block)
	);

	assign req.ready = req_ready;

endmodule
